// File: rtl/core/rrsd_pkg.sv
// ----------------------------------------------------------------------------
// rrsd_pkg
// Shared widths, reset values and the control word for the server cell row.
// ----------------------------------------------------------------------------
package rrsd_pkg;

  localparam int SERVERS_DEF  = 16;
  localparam int TIME_W       = 32;
  localparam int FREE_W       = 33;
  localparam int CNT_W        = 32;
  localparam int OIDX_W       = 4;
  localparam int SCNT_W       = 5;
  localparam int RESULT_LIMIT = 16;

  localparam logic [SCNT_W-1:0] SCNT_RST = SCNT_W'(16);

  typedef struct packed {
    logic cmp;
    logic pick;
    logic upd;
    logic load;
    logic shift;
  } rrsd_ctrl_t;

endpackage

// File: rtl/core/rrsd_cell.sv
// ----------------------------------------------------------------------------
// rrsd_cell
// One server: free time, job count, free test, priority link and scan stage.
// ----------------------------------------------------------------------------
module rrsd_cell
  import rrsd_pkg::*;
#(
  parameter int MAX_SERVERS = SERVERS_DEF,
  parameter int IDX         = 0
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rrsd_ctrl_t                  ctrl,
  input  logic [$clog2(MAX_SERVERS+1)-1:0] n_i,
  input  logic [((MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1)-1:0] start_i,
  input  logic [TIME_W-1:0]           arrival,
  input  logic [FREE_W-1:0]           sum,
  input  logic                        seen_a_i,
  input  logic                        seen_b_i,
  output logic                        seen_a_o,
  output logic                        seen_b_o,
  input  logic                        use_a,
  input  logic [CNT_W-1:0]            scan_i,
  output logic [CNT_W-1:0]            scan_o,
  output logic [CNT_W-1:0]            cnt_sel_o,
  output logic                        grant_o
);

  localparam int NW    = $clog2(MAX_SERVERS + 1);
  localparam int IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;

  logic [FREE_W-1:0] ft_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  scan_r;
  logic              free_r;
  logic              grant_r;
  logic              active;
  logic              in_rot;
  logic              grant_a;
  logic              grant_b;

  assign active   = NW'(IDX) < n_i;
  assign in_rot   = IDX_W'(IDX) >= start_i;
  assign grant_a  = free_r & in_rot & ~seen_a_i;
  assign grant_b  = free_r & ~seen_b_i;
  assign seen_a_o = seen_a_i | (free_r & in_rot);
  assign seen_b_o = seen_b_i | free_r;

  assign scan_o    = scan_r;
  assign grant_o   = grant_r;
  assign cnt_sel_o = grant_r ? cnt_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ft_r    <= '0;
      cnt_r   <= '0;
      free_r  <= 1'b0;
      grant_r <= 1'b0;
    end else begin
      if (ctrl.cmp) begin
        free_r <= active & (ft_r <= {1'b0, arrival});
      end
      if (ctrl.pick) begin
        grant_r <= use_a ? grant_a : grant_b;
      end
      if (ctrl.upd && grant_r) begin
        ft_r <= sum;
        if (cnt_r != '1) begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
      end
    end
  end

  // scan stage, hands counts towards server 0
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      scan_r <= cnt_r;
    end else if (ctrl.shift) begin
      scan_r <= scan_i;
    end
  end

endmodule

// File: rtl/core/round_robin_server_dispatcher.sv
// ----------------------------------------------------------------------------
// round_robin_server_dispatcher
// Round-robin job dispatch over a row of server cells, with busiest report.
// ----------------------------------------------------------------------------
// A dispatch word goes through these steps from acceptance to its result
// word in the output register: free test in every cell, a rippling priority
// link through the row from the start position, the cell update, and result
// collection. For a report word, counts are shifted through the row to
// server 0 once to find the maximum and tie count, then again to emit each
// tie. One word is in work at a time; the next is accepted once the result
// of the current one is in the output register. Result words stall the scan
// while the output register stays full.
module round_robin_server_dispatcher
  import rrsd_pkg::*;
#(
  parameter int MAX_SERVERS = SERVERS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [SCNT_W-1:0]    cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_action,
  input  logic [TIME_W-1:0]    in_arrival_time,
  input  logic [TIME_W-1:0]    in_service_time,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [OIDX_W-1:0]    out_server_index,
  output logic                 out_dropped,
  output logic [CNT_W-1:0]     out_handled_count,
  output logic                 out_last
);

  localparam int NW    = $clog2(MAX_SERVERS + 1);
  localparam int IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int LW    = (NW > SCNT_W) ? NW : SCNT_W;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_CMP  = 8'b0000_0010,
    S_PICK = 8'b0000_0100,
    S_UPD  = 8'b0000_1000,
    S_RES  = 8'b0001_0000,
    S_MAX  = 8'b0010_0000,
    S_RLD  = 8'b0100_0000,
    S_EMIT = 8'b1000_0000
  } state_t;

  state_t             state_r, state_nxt;
  logic [SCNT_W-1:0]  scnt_r;
  logic [IDX_W-1:0]   start_r, start_nxt;
  logic [IDX_W-1:0]   startq_r;
  logic [NW-1:0]      n_r;
  logic [NW-1:0]      n_cur;
  logic [TIME_W-1:0]  arr_r;
  logic [TIME_W-1:0]  svc_r;
  logic [FREE_W-1:0]  sum;
  logic               found_r;
  logic [CNT_W-1:0]   max_r, max_nxt;
  logic [NW-1:0]      ties_r, ties_nxt;
  logic [NW-1:0]      k_r, k_nxt;
  logic [SCNT_W-1:0]  emit_r, emit_nxt;
  logic [SCNT_W-1:0]  emit_inc;
  logic               emit_last;

  logic               out_valid_r;
  logic [OIDX_W-1:0]  out_idx_r;
  logic               out_drop_r;
  logic [CNT_W-1:0]   out_cnt_r;
  logic               out_last_r;
  logic               slot_free;
  logic               in_fire;

  rrsd_ctrl_t         ctrl;
  logic [MAX_SERVERS:0]  seen_a;
  logic [MAX_SERVERS:0]  seen_b;
  logic [CNT_W-1:0]      scan_w   [MAX_SERVERS];
  logic [CNT_W-1:0]      scan_nb  [MAX_SERVERS];
  logic [CNT_W-1:0]      cnt_sel  [MAX_SERVERS];
  logic [MAX_SERVERS-1:0] grant;
  logic [CNT_W-1:0]      pick_cnt;
  logic [IDX_W-1:0]      pick_idx;
  logic [CNT_W-1:0]      head;
  logic [NW-1:0]         start_inc;

  // active server count from the register
  always_comb begin
    if (scnt_r == '0) begin
      n_cur = NW'(1);
    end else if (32'(scnt_r) > MAX_SERVERS) begin
      n_cur = NW'(MAX_SERVERS);
    end else begin
      n_cur = NW'(scnt_r);
    end
  end

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign sum       = {1'b0, arr_r} + {1'b0, svc_r};
  assign head      = scan_w[0];

  assign seen_a[0] = 1'b0;
  assign seen_b[0] = 1'b0;

  for (genvar g = 0; g < MAX_SERVERS; g++) begin : g_cell
    if (g == MAX_SERVERS - 1) begin : g_end
      assign scan_nb[g] = '0;
    end else begin : g_mid
      assign scan_nb[g] = scan_w[g+1];
    end

    rrsd_cell #(
      .MAX_SERVERS(MAX_SERVERS),
      .IDX        (g)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .n_i      (n_r),
      .start_i  (startq_r),
      .arrival  (arr_r),
      .sum      (sum),
      .seen_a_i (seen_a[g]),
      .seen_b_i (seen_b[g]),
      .seen_a_o (seen_a[g+1]),
      .seen_b_o (seen_b[g+1]),
      .use_a    (seen_a[MAX_SERVERS]),
      .scan_i   (scan_nb[g]),
      .scan_o   (scan_w[g]),
      .cnt_sel_o(cnt_sel[g]),
      .grant_o  (grant[g])
    );
  end

  // granted cell count and index
  always_comb begin
    pick_cnt = '0;
    pick_idx = '0;
    for (int i = 0; i < MAX_SERVERS; i++) begin
      pick_cnt = pick_cnt | cnt_sel[i];
      pick_idx = pick_idx | (grant[i] ? IDX_W'(i) : IDX_W'(0));
    end
  end

  // rotating start for the word being accepted
  always_comb begin
    logic [IDX_W-1:0] s_eff;
    s_eff     = (NW'(start_r) < n_cur) ? start_r : '0;
    start_inc = NW'(s_eff) + NW'(1);
    start_nxt = (start_inc >= n_cur) ? '0 : IDX_W'(start_inc);
  end

  assign emit_inc  = emit_r + SCNT_W'(1);
  assign emit_last = (LW'(emit_inc) == LW'(ties_r)) ||
                     (32'(emit_inc) == RESULT_LIMIT);

  always_comb begin
    state_nxt  = state_r;
    ctrl       = '0;
    max_nxt    = max_r;
    ties_nxt   = ties_r;
    k_nxt      = k_r;
    emit_nxt   = emit_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_action) begin
            ctrl.load = 1'b1;
            max_nxt   = '0;
            ties_nxt  = '0;
            k_nxt     = '0;
            state_nxt = S_MAX;
          end else begin
            state_nxt = S_CMP;
          end
        end
      end
      S_CMP: begin
        ctrl.cmp  = 1'b1;
        state_nxt = S_PICK;
      end
      S_PICK: begin
        ctrl.pick = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        ctrl.upd  = 1'b1;
        state_nxt = S_RES;
      end
      S_RES: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_MAX: begin
        ctrl.shift = 1'b1;
        if (head > max_r) begin
          max_nxt  = head;
          ties_nxt = NW'(1);
        end else if (head == max_r) begin
          ties_nxt = ties_r + NW'(1);
        end
        k_nxt = k_r + NW'(1);
        if (k_r == n_r - NW'(1)) begin
          state_nxt = S_RLD;
        end
      end
      S_RLD: begin
        ctrl.load = 1'b1;
        k_nxt     = '0;
        emit_nxt  = '0;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (head != max_r) begin
          ctrl.shift = 1'b1;
          k_nxt      = k_r + NW'(1);
        end else if (slot_free) begin
          ctrl.shift = 1'b1;
          k_nxt      = k_r + NW'(1);
          emit_nxt   = emit_inc;
          if (emit_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      scnt_r  <= SCNT_RST;
      start_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        scnt_r <= cfg_wdata;
      end
      if (in_fire && !in_action) begin
        start_r <= start_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      arr_r    <= in_arrival_time;
      svc_r    <= in_service_time;
      n_r      <= n_cur;
      startq_r <= (NW'(start_r) < n_cur) ? start_r : '0;
    end
    if (ctrl.pick) begin
      found_r <= seen_b[MAX_SERVERS];
    end
    max_r  <= max_nxt;
    ties_r <= ties_nxt;
    k_r    <= k_nxt;
    emit_r <= emit_nxt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_RES && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (state_r == S_EMIT && head == max_r && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_RES && slot_free) begin
      out_idx_r  <= OIDX_W'(pick_idx);
      out_drop_r <= !found_r;
      out_cnt_r  <= pick_cnt;
      out_last_r <= 1'b1;
    end else if (state_r == S_EMIT && head == max_r && slot_free) begin
      out_idx_r  <= OIDX_W'(k_r);
      out_drop_r <= 1'b0;
      out_cnt_r  <= max_r;
      out_last_r <= emit_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_server_index  = out_idx_r;
  assign out_dropped       = out_drop_r;
  assign out_handled_count = out_cnt_r;
  assign out_last          = out_last_r;

endmodule
